// ===== rtl/pss_pkg.sv =====
// Shared types, codes and widths of the playback step sequencer.
`default_nettype none

package pss_pkg;

  // Default width of the stored step index
  localparam int unsigned STEP_BITS_DEF = 16;

  // Fixed field and register widths
  localparam int unsigned OPND_BITS     = 16;
  localparam int unsigned FUNC_BITS     = 2;
  localparam int unsigned MODE_BITS     = 3;
  localparam int unsigned CNT_BITS      = 16;
  localparam int unsigned CFG_ADDR_BITS = 1;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned IDX_OUT_BITS  = 16;
  localparam int unsigned S_TDATA_BITS  = 16;
  localparam int unsigned M_TDATA_BITS  = 24;

  // Remainder unit retires one operand bit per cycle
  localparam int unsigned BIT_CNT_BITS = $clog2(OPND_BITS);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_FWD_CLAMP = 3'd0,
    MODE_FWD_LOOP  = 3'd1,
    MODE_BWD_CLAMP = 3'd2,
    MODE_BWD_LOOP  = 3'd3,
    MODE_PINGPONG  = 3'd4
  } mode_e;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_ADVANCE = 2'd0,
    FUNC_JUMP    = 2'd1,
    FUNC_PREVIEW = 2'd2,
    FUNC_HOLD    = 2'd3
  } func_e;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_PLAY_MODE  = 1'b0,
    REG_STEP_COUNT = 1'b1
  } reg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture beat, clamp current step, arm remainder unit
    logic step;    // one remainder iteration
    logic commit;  // update state and output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // current iteration is the last one
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/pss_ctrl.sv =====
// Controller state machine of the playback step sequencer.
`default_nettype none

module pss_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_valid_i,
  output logic                        s_ready_o,
  input  wire logic                   m_ready_i,
  output logic                        m_valid_o,
  input  wire pss_pkg::dp_status_t    status_i,
  output pss_pkg::ctrl_cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Sequence one item: accept, iterate, commit
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_q || m_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Track the output beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/pss_datapath.sv =====
// Datapath of the playback step sequencer: registers, remainder unit, step math.
`default_nettype none

module pss_datapath #(
  parameter int unsigned STEP_BITS = pss_pkg::STEP_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pss_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  wire logic [pss_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  input  wire logic [pss_pkg::FUNC_BITS-1:0]       func_i,
  input  wire logic [pss_pkg::OPND_BITS-1:0]       operand_i,
  input  wire pss_pkg::ctrl_cmd_t                  cmd_i,
  output pss_pkg::dp_status_t                      status_o,
  output logic [pss_pkg::IDX_OUT_BITS-1:0]         step_index_o,
  output logic                                     moving_forward_o
);

  // Count bits that reach the step range
  localparam int unsigned CW = (STEP_BITS < pss_pkg::CNT_BITS) ? STEP_BITS : pss_pkg::CNT_BITS;
  // Arithmetic width: covers step, operand and twice the last step with carry
  localparam int unsigned AW = ((STEP_BITS > pss_pkg::OPND_BITS) ? STEP_BITS
                                                                 : pss_pkg::OPND_BITS) + 2;
  localparam int unsigned DW = STEP_BITS + 1;
  localparam int unsigned RW = STEP_BITS + 2;

  // Configuration and playback state
  logic [pss_pkg::MODE_BITS-1:0] mode_q;
  logic [pss_pkg::CNT_BITS-1:0]  count_q;
  logic [STEP_BITS-1:0]          cur_q;
  logic                          fwd_q;

  // Per-item working registers
  logic [STEP_BITS-1:0]                 last_q;
  logic [DW-1:0]                        div_q;
  logic [pss_pkg::FUNC_BITS-1:0]        func_q;
  logic [pss_pkg::OPND_BITS-1:0]        opnd_q;
  logic [pss_pkg::OPND_BITS-1:0]        sh_q;
  logic [RW-1:0]                        rem_q;
  logic [pss_pkg::BIT_CNT_BITS-1:0]     bit_q;
  logic [pss_pkg::IDX_OUT_BITS-1:0]     out_idx_q;
  logic                                 out_fwd_q;

  logic [CW-1:0]        cnt_m;
  logic [STEP_BITS-1:0] last_c;
  logic [STEP_BITS-1:0] cur_clamp;
  logic [DW-1:0]        div_c;
  logic [RW-1:0]        rem_sh;
  logic [RW-1:0]        rem_d;

  logic [AW-1:0] cur_a, last_a, n_a, r_a, m_a, p_a;
  logic [AW-1:0] sum_a, t_a, phase_a, np_a, adv_a, jump_a, res_a;
  logic          adv_dir, jump_fwd, nxt_fwd;
  logic [STEP_BITS-1:0] nxt_cur;

  // Last step index and clamp of the current step
  assign cnt_m     = count_q[CW-1:0];
  assign last_c    = (cnt_m == '0) ? '0 : STEP_BITS'(cnt_m - CW'(1));
  assign cur_clamp = (cur_q > last_c) ? last_c : cur_q;
  // Divisor: ping-pong phase period, otherwise step count
  assign div_c     = (mode_q == pss_pkg::MODE_PINGPONG) ? {last_c, 1'b0}
                                                        : DW'(last_c) + DW'(1);

  // Restoring remainder, one operand bit per step
  assign rem_sh = {rem_q[RW-2:0], sh_q[pss_pkg::OPND_BITS-1]};
  assign rem_d  = (rem_sh >= RW'(div_q)) ? rem_sh - RW'(div_q) : rem_sh;

  assign status_o.div_last = (bit_q == '0);

  // Operands at common width
  assign cur_a  = AW'(cur_q);
  assign last_a = AW'(last_q);
  assign n_a    = AW'(opnd_q);
  assign r_a    = AW'(rem_q);
  assign m_a    = last_a + AW'(1);
  assign p_a    = {last_a[AW-2:0], 1'b0};
  assign sum_a  = cur_a + n_a;

  // Advance by the operand in the configured mode
  always_comb begin
    adv_dir = fwd_q;
    adv_a   = '0;
    t_a     = '0;
    phase_a = '0;
    np_a    = '0;
    unique case (pss_pkg::mode_e'(mode_q))
      pss_pkg::MODE_FWD_LOOP: begin
        t_a   = cur_a + r_a;
        adv_a = (t_a >= m_a) ? t_a - m_a : t_a;
      end
      pss_pkg::MODE_BWD_CLAMP: begin
        adv_a = (cur_a > n_a) ? cur_a - n_a : '0;
      end
      pss_pkg::MODE_BWD_LOOP: begin
        t_a   = cur_a + m_a - r_a;
        adv_a = (t_a >= m_a) ? t_a - m_a : t_a;
      end
      pss_pkg::MODE_PINGPONG: begin
        // unfold onto the phase cycle, add, fold back
        if (last_a != '0) begin
          if (fwd_q) begin
            phase_a = cur_a;
          end else begin
            phase_a = (cur_a == '0) ? '0 : p_a - cur_a;
          end
          t_a     = phase_a + r_a;
          np_a    = (t_a >= p_a) ? t_a - p_a : t_a;
          adv_dir = (np_a < last_a);
          adv_a   = (np_a <= last_a) ? np_a : p_a - np_a;
        end
      end
      default: begin
        adv_a = (sum_a < last_a) ? sum_a : last_a;
      end
    endcase
  end

  // Jump target and direction
  assign jump_a   = (n_a < last_a) ? n_a : last_a;
  assign jump_fwd = (mode_q == pss_pkg::MODE_PINGPONG) ? (n_a > cur_a) : fwd_q;

  // Select next state and result by operation
  always_comb begin
    nxt_cur = cur_q;
    nxt_fwd = fwd_q;
    res_a   = cur_a;
    unique case (pss_pkg::func_e'(func_q))
      pss_pkg::FUNC_ADVANCE: begin
        nxt_cur = adv_a[STEP_BITS-1:0];
        nxt_fwd = adv_dir;
        res_a   = adv_a;
      end
      pss_pkg::FUNC_JUMP: begin
        nxt_cur = jump_a[STEP_BITS-1:0];
        nxt_fwd = jump_fwd;
        res_a   = jump_a;
      end
      pss_pkg::FUNC_PREVIEW: begin
        res_a = adv_a;
      end
      pss_pkg::FUNC_HOLD: begin
        res_a = cur_a;
      end
      default: res_a = cur_a;
    endcase
  end

  // Configuration registers and playback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pss_pkg::MODE_FWD_CLAMP;
      count_q <= pss_pkg::CNT_BITS'(1);
      cur_q   <= '0;
      fwd_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (pss_pkg::reg_idx_e'(cfg_addr_i))
          pss_pkg::REG_PLAY_MODE:  mode_q  <= cfg_wdata_i[pss_pkg::MODE_BITS-1:0];
          pss_pkg::REG_STEP_COUNT: count_q <= cfg_wdata_i[pss_pkg::CNT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        cur_q <= cur_clamp;
      end else if (cmd_i.commit) begin
        cur_q <= nxt_cur;
        fwd_q <= nxt_fwd;
      end
    end
  end

  // Working registers and output beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q <= last_c;
      div_q  <= div_c;
      func_q <= func_i;
      opnd_q <= operand_i;
      sh_q   <= operand_i;
      rem_q  <= '0;
      bit_q  <= pss_pkg::BIT_CNT_BITS'(pss_pkg::OPND_BITS - 1);
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      sh_q  <= sh_q << 1;
      bit_q <= bit_q - pss_pkg::BIT_CNT_BITS'(1);
    end
    if (cmd_i.commit) begin
      out_idx_q <= res_a[pss_pkg::IDX_OUT_BITS-1:0];
      out_fwd_q <= nxt_fwd;
    end
  end

  assign step_index_o     = out_idx_q;
  assign moving_forward_o = out_fwd_q;

endmodule

`default_nettype wire

// ===== rtl/playback_step_sequencer_unit.sv =====
// Top level of the playback step sequencer: controller, datapath and checks.
//
//  channel  | direction | signals                          | contents
//  s_axis   | in        | tvalid tready tdata tuser        | command beat: operand, func
//  m_axis   | out       | tvalid tready tdata              | result beat: step, direction
//  cfg      | in        | cfg_we_i cfg_addr_i cfg_wdata_i  | play_mode (0), step_count (1)
//
// An accepted beat is captured with its current step clamped, then passes the remainder
// unit (one operand bit per cycle), then is computed and committed to the output register.
// The next beat is accepted the cycle after commit. A result that is not taken stalls
// the next item in its commit step, and no new beat is accepted until that commit happens.
// Reset clears play_mode to 0, step_count to 1, current step and direction to 0.
`default_nettype none

module playback_step_sequencer_unit #(
  parameter int unsigned STEP_BITS = pss_pkg::STEP_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [pss_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  wire logic [pss_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  // command stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [pss_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,  // [15:0] operand
  input  wire logic [pss_pkg::FUNC_BITS-1:0]       s_axis_tuser,  // [1:0] func
  // result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [pss_pkg::M_TDATA_BITS-1:0]         m_axis_tdata   // [15:0] step_index,
                                                                   // [16] moving_forward
);

  pss_pkg::ctrl_cmd_t  cmd;
  pss_pkg::dp_status_t status;

  logic [pss_pkg::IDX_OUT_BITS-1:0] step_index;
  logic                             moving_forward;

  pss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pss_datapath #(
    .STEP_BITS (STEP_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .func_i           (s_axis_tuser),
    .operand_i        (s_axis_tdata),
    .cmd_i            (cmd),
    .status_o         (status),
    .step_index_o     (step_index),
    .moving_forward_o (moving_forward)
  );

  // Pack the result beat
  assign m_axis_tdata = {{(pss_pkg::M_TDATA_BITS - pss_pkg::IDX_OUT_BITS - 1){1'b0}},
                         moving_forward, step_index};

`ifndef NO_ASSERTIONS
  // Busy right after a command beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command accepted on two consecutive cycles");

  // Load happens exactly on an accepted command beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (s_axis_tvalid && s_axis_tready))
    else $error("load without an accepted command beat");

  // Commit never overwrites a result beat that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("commit over an untaken result beat");

  // A result beat appears only after a commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.commit))
    else $error("result beat without commit");
`endif

endmodule

`default_nettype wire
